// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define SES_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ses assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define SES_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ses assertion failed");

`endif

// ===== rtl/ses_pkg.sv =====
package ses_pkg;

  localparam int COORD_W      = 32;
  localparam int EDGE_W       = 33;
  localparam int PROD_W       = 66;
  localparam int COF_W        = 69;
  localparam int COF_LO_W     = 35;
  localparam int PP_W         = 72;
  localparam int DET_W        = 104;
  localparam int DOT_W        = 140;
  localparam int ENTRY_W      = 48;
  localparam int ROW_W        = 2;
  localparam int NVERT        = 4;
  localparam int NAX          = 3;
  localparam int QBITS        = 49;
  localparam int OUT_FRAC     = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_TDATA_W   = 384;
  localparam int OUT_TDATA_W  = 200;
  localparam int OUT_USED_W   = ROW_W + NVERT * ENTRY_W;

  typedef enum logic [1:0] {
    DIM_NONE = 2'd0,
    DIM_SEG  = 2'd1,
    DIM_TRI  = 2'd2,
    DIM_TET  = 2'd3
  } dim_t;

  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  // per-row control travelling with the divider lanes
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             deg;
    logic             last;
    logic [NVERT-1:0] neg;
  } row_ctl_t;

  function automatic int den_width(int frac);
    return DET_W + 3 + frac;
  endfunction

  function automatic int num_width(int frac);
    int a;
    int b;
    a = DOT_W + OUT_FRAC + frac + 2;
    b = den_width(frac) + 1 + QBITS;
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/ses_front.sv =====
module ses_front import ses_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W = num_width(FRAC_BITS),
  localparam int DEN_W = den_width(FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROW_W-1:0]      in_row,
  input  dim_t                  in_dim,
  input  logic [IN_TDATA_W-1:0] in_coords,
  output logic                  out_valid,
  output row_ctl_t              out_ctl,
  output logic [NUM_W-1:0]      out_num [NVERT],
  output logic [NUM_W-1:0]      out_dv
);

  logic             v_r   [1:8];
  logic [ROW_W-1:0] row_r [1:7];
  dim_t             dim_r [1:7];

  edge_t e_nxt  [1:3][0:2];
  edge_t e1_r   [1:3][0:2];
  edge_t e2_r   [1:3][0:2];
  prod_t pa_nxt [1:3][0:2];
  prod_t pb_nxt [1:3][0:2];
  prod_t pa_r   [1:3][0:2];
  prod_t pb_r   [1:3][0:2];
  cof_t  n_nxt  [0:3][0:2];
  cof_t  n_r    [0:3][0:2];
  cof_t  nrow_r [0:2];
  edge_t e3_r   [0:2];
  pp_t   hh_nxt [0:3][0:2];
  pp_t   hl_nxt [0:3][0:2];
  pp_t   lh_nxt [0:3][0:2];
  pp_t   ll_nxt [0:3][0:2];
  pp_t   hh_r   [0:3][0:2];
  pp_t   hl_r   [0:3][0:2];
  pp_t   lh_r   [0:3][0:2];
  pp_t   ll_r   [0:3][0:2];
  pp_t   dh_nxt [0:2];
  pp_t   dl_nxt [0:2];
  pp_t   dh_r   [0:2];
  pp_t   dl_r   [0:2];
  dot_t  dota_nxt [0:3][0:2];
  dot_t  dota_r   [0:3][0:2];
  det_t  deta_nxt [0:2];
  det_t  deta_r   [0:2];
  dot_t  dot_nxt [0:3];
  dot_t  dot_r   [0:3];
  det_t  det_nxt;
  det_t  det_r;
  logic [DOT_W-1:0] mag_nxt [0:3];
  logic [DOT_W-1:0] mag_r   [0:3];
  logic [DET_W-1:0] det_abs;
  logic [DEN_W-1:0] den_nxt;
  logic [DEN_W-1:0] den_r;
  row_ctl_t         ctl_nxt;
  row_ctl_t         ctl7_r;
  row_ctl_t         ctl8_r;
  logic [NUM_W-1:0] num_nxt [NVERT];
  logic [NUM_W-1:0] num_r   [NVERT];
  logic [NUM_W-1:0] dv_nxt;
  logic [NUM_W-1:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 8; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= 8; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r[1] <= in_row;
      dim_r[1] <= in_dim;
      for (int k = 2; k <= 7; k++) begin
        row_r[k] <= row_r[k-1];
        dim_r[k] <= dim_r[k-1];
      end
    end
  end

  // S1: edge vectors from vertex 0, unused ones forced to zero
  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        if (k <= int'(in_dim) && a < int'(in_dim)) begin
          e_nxt[k][a] = edge_t'($signed(in_coords[(k*3+a)*COORD_W +: COORD_W]))
                      - edge_t'($signed(in_coords[a*COORD_W +: COORD_W]));
        end else begin
          e_nxt[k][a] = '0;
        end
      end
    end
  end

  // S2: cross product terms
  always_comb begin
    int p;
    int s;
    int b1;
    int b2;
    for (int i = 1; i <= 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        p  = (i % 3) + 1;
        s  = ((i + 1) % 3) + 1;
        b1 = (a + 1) % 3;
        b2 = (a + 2) % 3;
        pa_nxt[i][a] = prod_t'(e1_r[p][b1]) * prod_t'(e1_r[s][b2]);
        pb_nxt[i][a] = prod_t'(e1_r[p][b2]) * prod_t'(e1_r[s][b1]);
      end
    end
  end

  // S3: cofactor vectors per dimension; vertex 0 takes minus their sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int a = 0; a < 3; a++) n_nxt[i][a] = '0;
    end
    unique case (dim_r[2])
      DIM_TET: begin
        for (int i = 1; i <= 3; i++) begin
          for (int a = 0; a < 3; a++) begin
            n_nxt[i][a] = cof_t'(pa_r[i][a]) - cof_t'(pb_r[i][a]);
          end
        end
      end
      DIM_TRI: begin
        n_nxt[1][0] = cof_t'(e2_r[2][1]);
        n_nxt[1][1] = -cof_t'(e2_r[2][0]);
        n_nxt[2][0] = -cof_t'(e2_r[1][1]);
        n_nxt[2][1] = cof_t'(e2_r[1][0]);
      end
      DIM_SEG:  n_nxt[1][0] = cof_t'(1);
      DIM_NONE: n_nxt[1][0] = '0;
    endcase
    for (int a = 0; a < 3; a++) begin
      n_nxt[0][a] = -(n_nxt[1][a] + n_nxt[2][a] + n_nxt[3][a]);
    end
  end

  // S4: split 69-bit operands into signed high and unsigned low halves
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int a = 0; a < 3; a++) begin
        hh_nxt[j][a] = pp_t'($signed(nrow_r[a][COF_W-1:COF_LO_W]))
                     * pp_t'($signed(n_r[j][a][COF_W-1:COF_LO_W]));
        hl_nxt[j][a] = pp_t'($signed(nrow_r[a][COF_W-1:COF_LO_W]))
                     * pp_t'($signed({1'b0, n_r[j][a][COF_LO_W-1:0]}));
        lh_nxt[j][a] = pp_t'($signed({1'b0, nrow_r[a][COF_LO_W-1:0]}))
                     * pp_t'($signed(n_r[j][a][COF_W-1:COF_LO_W]));
        ll_nxt[j][a] = pp_t'($signed({1'b0, nrow_r[a][COF_LO_W-1:0]}))
                     * pp_t'($signed({1'b0, n_r[j][a][COF_LO_W-1:0]}));
      end
    end
    for (int a = 0; a < 3; a++) begin
      dh_nxt[a] = pp_t'(e3_r[a]) * pp_t'($signed(n_r[1][a][COF_W-1:COF_LO_W]));
      dl_nxt[a] = pp_t'(e3_r[a]) * pp_t'($signed({1'b0, n_r[1][a][COF_LO_W-1:0]}));
    end
  end

  // S5: recombine partial products
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int a = 0; a < 3; a++) begin
        dota_nxt[j][a] = (dot_t'(hh_r[j][a]) <<< (2 * COF_LO_W))
                       + ((dot_t'(hl_r[j][a]) + dot_t'(lh_r[j][a])) <<< COF_LO_W)
                       + dot_t'(ll_r[j][a]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      deta_nxt[a] = (det_t'(dh_r[a]) <<< COF_LO_W) + det_t'(dl_r[a]);
    end
  end

  // S6: sum over axes
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dot_nxt[j] = dota_r[j][0] + dota_r[j][1] + dota_r[j][2];
    end
    det_nxt = deta_r[0] + deta_r[1] + deta_r[2];
  end

  // S7: signs, magnitudes, denominator c*|det| (tetrahedra also scaled by 2^FRAC)
  always_comb begin
    det_abs = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    unique case (dim_r[6])
      DIM_TET: den_nxt = ((DEN_W'(det_abs) << 2) + (DEN_W'(det_abs) << 1)) << FRAC_BITS;
      DIM_TRI: den_nxt = DEN_W'(det_abs) << 1;
      DIM_SEG: den_nxt = DEN_W'(det_abs);
      DIM_NONE: den_nxt = DEN_W'(det_abs);
    endcase
    ctl_nxt.row  = row_r[6];
    ctl_nxt.deg  = (det_r == '0);
    ctl_nxt.last = (row_r[6] == ROW_W'(dim_r[6]));
    for (int j = 0; j < 4; j++) begin
      ctl_nxt.neg[j] = dot_r[j][DOT_W-1];
      mag_nxt[j]     = dot_r[j][DOT_W-1] ? DOT_W'(-dot_r[j]) : DOT_W'(dot_r[j]);
    end
  end

  // S8: rounding numerator 2*mag*2^sh + den, divisor 2*den
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (dim_r[7] == DIM_SEG) begin
        num_nxt[j] = (NUM_W'(mag_r[j]) << (OUT_FRAC + FRAC_BITS + 1)) + NUM_W'(den_r);
      end else begin
        num_nxt[j] = (NUM_W'(mag_r[j]) << (OUT_FRAC + 1)) + NUM_W'(den_r);
      end
    end
    dv_nxt = NUM_W'(den_r) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= e_nxt;
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      e2_r   <= e1_r;
      n_r    <= n_nxt;
      for (int a = 0; a < 3; a++) begin
        nrow_r[a] <= n_nxt[row_r[2]][a];
        e3_r[a]   <= e2_r[1][a];
      end
      hh_r   <= hh_nxt;
      hl_r   <= hl_nxt;
      lh_r   <= lh_nxt;
      ll_r   <= ll_nxt;
      dh_r   <= dh_nxt;
      dl_r   <= dl_nxt;
      dota_r <= dota_nxt;
      deta_r <= deta_nxt;
      dot_r  <= dot_nxt;
      det_r  <= det_nxt;
      mag_r  <= mag_nxt;
      den_r  <= den_nxt;
      ctl7_r <= ctl_nxt;
      num_r  <= num_nxt;
      dv_r   <= dv_nxt;
      ctl8_r <= ctl7_r;
    end
  end

  assign out_valid = v_r[8];
  assign out_ctl   = ctl8_r;
  assign out_num   = num_r;
  assign out_dv    = dv_r;

endmodule

// ===== rtl/ses_div.sv =====
module ses_div import ses_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W = num_width(FRAC_BITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  row_ctl_t         in_ctl,
  input  logic [NUM_W-1:0] in_num [NVERT],
  input  logic [NUM_W-1:0] in_dv,
  output logic             out_valid,
  output row_ctl_t         out_ctl,
  output entry_t           out_entry [NVERT]
);

  localparam logic [QBITS-1:0] LIM_POS = QBITS'((64'd1 << (ENTRY_W - 1)) - 64'd1);
  localparam logic [QBITS-1:0] LIM_NEG = QBITS'(64'd1 << (ENTRY_W - 1));

  logic             v_r   [0:QBITS];
  row_ctl_t         ctl_r [0:QBITS];
  logic [NUM_W-1:0] dvs_r [0:QBITS];
  logic [NUM_W-1:0] rem_r [0:QBITS][NVERT];
  logic [QBITS-1:0] q_r   [0:QBITS][NVERT];
  logic [NVERT-1:0] ovf_r [0:QBITS];
  logic [NVERT-1:0] ovf_nxt;

  logic             out_v_r;
  row_ctl_t         out_ctl_r;
  entry_t           entry_r   [NVERT];
  entry_t           entry_nxt [NVERT];

  // quotient would not fit in QBITS bits: saturate outright
  always_comb begin
    for (int l = 0; l < NVERT; l++) ovf_nxt[l] = (in_num[l] >= (in_dv << QBITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= in_ctl;
      ovf_r[0] <= ovf_nxt;
      dvs_r[0] <= in_dv << (QBITS - 1);
      for (int l = 0; l < NVERT; l++) begin
        rem_r[0][l] <= in_num[l];
        q_r[0][l]   <= '0;
      end
    end
  end

  // one restoring quotient bit per stage, four lanes side by side
  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [NUM_W-1:0] rem_nxt [NVERT];
    logic [NVERT-1:0] ge;

    always_comb begin
      for (int l = 0; l < NVERT; l++) begin
        ge[l]      = (rem_r[s][l] >= dvs_r[s]);
        rem_nxt[l] = ge[l] ? (rem_r[s][l] - dvs_r[s]) : rem_r[s][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s+1] <= ctl_r[s];
        ovf_r[s+1] <= ovf_r[s];
        dvs_r[s+1] <= dvs_r[s] >> 1;
        for (int l = 0; l < NVERT; l++) begin
          rem_r[s+1][l] <= rem_nxt[l];
          q_r[s+1][l]   <= {q_r[s][l][QBITS-2:0], ge[l]};
        end
      end
    end
  end

  // saturate, restore sign, blank degenerate rows
  always_comb begin
    logic [QBITS-1:0] lim;
    logic [QBITS-1:0] m;
    for (int l = 0; l < NVERT; l++) begin
      lim = ctl_r[QBITS].neg[l] ? LIM_NEG : LIM_POS;
      m   = (ovf_r[QBITS][l] || (q_r[QBITS][l] > lim)) ? lim : q_r[QBITS][l];
      if (ctl_r[QBITS].deg) begin
        entry_nxt[l] = '0;
      end else if (ctl_r[QBITS].neg[l]) begin
        entry_nxt[l] = -entry_t'(m[ENTRY_W-1:0]);
      end else begin
        entry_nxt[l] = entry_t'(m[ENTRY_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl_r <= ctl_r[QBITS];
      entry_r   <= entry_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_ctl   = out_ctl_r;
  assign out_entry = entry_r;

endmodule

// ===== rtl/simplex_element_stiffness_top.sv =====
// Linear simplex element stiffness. Each input transaction carries the four
// vertices of one element in Q16.16 (FRAC_BITS); the dimension register picks
// segment (1), triangle (2) or tetrahedron (3). The block returns one output
// transaction per vertex, rows 0..dimension in order, each holding K(i,0..3) =
// measure * grad_i . grad_j in signed Q24.24, rounded to nearest (ties away
// from zero) and saturated to 48 bits. Columns above the dimension read zero.
// A zero determinant flags every row degenerate with all entries zero. With
// dimension 0 an element is taken and dropped without output.
// Throughput: one row per advancing cycle, so an element spans dimension+1 rows
// (4 for a tetrahedron); the input holding register issues the rows and takes
// the next element in the cycle its last row leaves. From input transaction to
// the first row the path runs through 1 holding stage, 8 arithmetic stages,
// 1 saturation check, 49 divider stages (one quotient bit each) and the output
// register. The whole pipeline advances whenever the output register is empty
// or being taken, so stalls on out_tready hold every stage.
// Configuration writes are only legal while no element is in flight.
module simplex_element_stiffness_top import ses_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W = num_width(FRAC_BITS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // dimension register
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data,
  // element in
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // v0_x, v0_y, v0_z, v1_x .. v3_z, 32 bits each from bit 0
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // stiffness row out
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row_index[1:0], entry_col0..entry_col3 48 bits each, zero pad to 200
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // degenerate
  output logic [0:0]             out_tuser,
  // last_row
  output logic                   out_tlast
);

  dim_t                  dim_r;

  logic                  h_v_r;
  dim_t                  h_dim_r;
  logic [ROW_W-1:0]      h_cnt_r;
  logic [IN_TDATA_W-1:0] h_coords_r;
  logic                  h_done;
  logic                  en;

  logic                  fr_valid;
  row_ctl_t              fr_ctl;
  logic [NUM_W-1:0]      fr_num [NVERT];
  logic [NUM_W-1:0]      fr_dv;

  row_ctl_t              dv_ctl;
  entry_t                dv_entry [NVERT];

  // global advance: output register free or being drained
  assign en        = !out_tvalid || out_tready;
  assign h_done    = (h_cnt_r == ROW_W'(h_dim_r));
  assign in_tready = en && (!h_v_r || h_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_TET;
    end else if (cfg_wr_en) begin
      dim_r <= dim_t'(cfg_wr_data);
    end
  end

  // holding register: issues one row per advancing cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r   <= 1'b0;
      h_cnt_r <= '0;
    end else if (en) begin
      if (in_tvalid && in_tready) begin
        h_v_r   <= (dim_r != DIM_NONE);
        h_cnt_r <= '0;
      end else if (h_v_r) begin
        if (h_done) begin
          h_v_r <= 1'b0;
        end else begin
          h_cnt_r <= h_cnt_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      h_dim_r    <= dim_r;
      h_coords_r <= in_tdata;
    end
  end

  ses_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_v_r),
    .in_row    (h_cnt_r),
    .in_dim    (h_dim_r),
    .in_coords (h_coords_r),
    .out_valid (fr_valid),
    .out_ctl   (fr_ctl),
    .out_num   (fr_num),
    .out_dv    (fr_dv)
  );

  ses_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_ctl    (fr_ctl),
    .in_num    (fr_num),
    .in_dv     (fr_dv),
    .out_valid (out_tvalid),
    .out_ctl   (dv_ctl),
    .out_entry (dv_entry)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0),
                      dv_entry[3], dv_entry[2], dv_entry[1], dv_entry[0], dv_ctl.row};
  assign out_tuser = dv_ctl.deg;
  assign out_tlast = dv_ctl.last;

endmodule

// ===== rtl/ses_checker.sv =====
`include "assert_macros.svh"

module ses_checker import ses_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser,
  input logic                   out_tlast
);

  // stalled row holds
  `SES_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // pipeline comes out of reset empty
  `SES_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_tvalid)

  // degenerate rows carry zero entries only
  `SES_ASSERT_NOW(a_deg_zero, out_tvalid && out_tuser[0], out_tdata[OUT_USED_W-1:ROW_W] == '0)

  // final row of an element is never vertex 0
  `SES_ASSERT_NOW(a_last_row, out_tvalid && out_tlast, out_tdata[ROW_W-1:0] != '0)

endmodule

bind simplex_element_stiffness_top ses_checker u_ses_checker (.*);

// ===== tb/sv/simplex_element_stiffness_checker.sv =====
module simplex_element_stiffness_checker import ses_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [ROW_W-1:0]   row;
    logic [ENTRY_W-1:0] col [NVERT];
    logic               deg;
    logic               last;
  } stiff_row_t;

  stiff_row_t row_q [$];
  dim_t       dim_shadow;

  // round half away from zero of num/den, clamp to 48-bit signed
  function automatic logic [ENTRY_W-1:0] round_clamp(wide_t num, wide_t den);
    logic          neg;
    logic [255:0]  mag;
    logic [255:0]  q;
    logic [255:0]  lim;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 1) + den) / (den << 1);
    lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 1);
    if (q > lim) q = lim;
    return neg ? ENTRY_W'(-q) : ENTRY_W'(q);
  endfunction

  function automatic void predict_rows(dim_t d, logic [IN_TDATA_W-1:0] td);
    wide_t      e [NVERT][NAX];
    wide_t      n [NVERT][NAX];
    wide_t      det, den, acc, tmp;
    logic signed [COORD_W-1:0] c;
    int         dn, p, s, b1, b2;
    logic       deg;
    stiff_row_t r;
    dn = int'(d);
    for (int i = 0; i < NVERT; i++)
      for (int a = 0; a < NAX; a++) begin
        e[i][a] = '0;
        n[i][a] = '0;
      end
    for (int i = 1; i <= dn; i++)
      for (int a = 0; a < dn; a++) begin
        c = td[(i*3+a)*COORD_W +: COORD_W];
        e[i][a] = c;
        c = td[a*COORD_W +: COORD_W];
        tmp = c;
        e[i][a] = e[i][a] - tmp;
      end
    det = '0;
    case (d)
      DIM_SEG: begin
        n[1][0] = 1;
        det = e[1][0];
      end
      DIM_TRI: begin
        n[1][0] = e[2][1];  n[1][1] = -e[2][0];
        n[2][0] = -e[1][1]; n[2][1] = e[1][0];
        det = e[1][0] * e[2][1] - e[1][1] * e[2][0];
      end
      default: begin
        for (int i = 1; i <= 3; i++) begin
          p = (i % 3) + 1;
          s = ((i + 1) % 3) + 1;
          for (int a = 0; a < 3; a++) begin
            b1 = (a + 1) % 3;
            b2 = (a + 2) % 3;
            n[i][a] = e[p][b1] * e[s][b2] - e[p][b2] * e[s][b1];
          end
        end
        for (int a = 0; a < 3; a++) det = det + e[1][a] * n[1][a];
      end
    endcase
    for (int a = 0; a < dn; a++) begin
      acc = '0;
      for (int i = 1; i <= dn; i++) acc = acc + n[i][a];
      n[0][a] = -acc;
    end
    deg = (det == 0);
    if (det < 0) det = -det;
    den = det * ((d == DIM_SEG) ? 1 : ((d == DIM_TRI) ? 2 : 6));
    if (d == DIM_TET) den = den <<< FRAC_BITS_DEF;
    for (int i = 0; i <= dn; i++) begin
      r.row = ROW_W'(i);
      for (int j = 0; j < NVERT; j++) begin
        r.col[j] = '0;
        if (j <= dn && !deg) begin
          acc = '0;
          for (int a = 0; a < dn; a++) acc = acc + n[i][a] * n[j][a];
          acc = acc <<< (OUT_FRAC + ((d == DIM_SEG) ? FRAC_BITS_DEF : 0));
          r.col[j] = round_clamp(acc, den);
        end
      end
      r.deg = deg;
      r.last = (i == dn);
      row_q.push_back(r);
    end
  endfunction

  always_ff @(posedge clk) begin
    stiff_row_t exp_r;
    logic       bad;
    if (!rst_n) begin
      dim_shadow <= DIM_TET;
      fail_count <= 0;
      row_q.delete();
    end else begin
      if (cfg_wr_en) dim_shadow <= dim_t'(cfg_wr_data);
      if (in_tvalid && in_tready && dim_shadow != DIM_NONE)
        predict_rows(dim_shadow, in_tdata);
      if (out_tvalid && out_tready) begin
        if (row_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected row transaction: %h", out_tdata);
        end else begin
          exp_r = row_q.pop_front();
          bad = (exp_r.row != out_tdata[ROW_W-1:0]) || (exp_r.deg != out_tuser[0])
                || (exp_r.last != out_tlast);
          for (int j = 0; j < NVERT; j++)
            if (exp_r.col[j] != out_tdata[ROW_W + j*ENTRY_W +: ENTRY_W]) bad = 1'b1;
          if (bad) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("row mismatch: exp row %0d c0 %h c1 %h c2 %h c3 %h deg %b last %b",
                       exp_r.row, exp_r.col[0], exp_r.col[1], exp_r.col[2], exp_r.col[3],
                       exp_r.deg, exp_r.last,
                       " | got row %0d c0 %h c1 %h c2 %h c3 %h deg %b last %b",
                       out_tdata[1:0], out_tdata[49:2],
                       out_tdata[97:50], out_tdata[145:98], out_tdata[193:146],
                       out_tuser[0], out_tlast);
          end
        end
      end
    end
  end

  assign rows_pending = row_q.size();

endmodule

// ===== tb/sv/simplex_element_stiffness_top_tb.sv =====
module simplex_element_stiffness_top_tb import ses_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 70;   // longer than the first-row latency
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [1:0]             cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;
  int                     fail_count;
  int                     rows_pending;

  // idle percentages for the two sides, changed per regime
  int tx_idle_pct;
  int rx_idle_pct;

  simplex_element_stiffness_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  simplex_element_stiffness_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .rows_pending(rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // one element transaction; valid held until the handshake completes
  task automatic send_elem(input logic [IN_TDATA_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // let the pipeline empty before touching the dimension register;
  // dimension-0 elements leave no row behind, hence the extra drain
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input dim_t d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(input int kind);
    logic [31:0] v;
    case (kind)
      0: v = 32'($signed($urandom_range(16)) - 8) <<< 14;      // coarse, small
      1: v = $urandom();                                           // full range
      2: case ($urandom_range(3))
           0: v = 32'h8000_0000;
           1: v = 32'h7FFF_FFFF;
           2: v = 32'h0000_0000;
           default: v = 32'hFFFF_FFFF;
         endcase
      default: v = {{12{$urandom_range(1) == 1}}, 20'($urandom())};  // medium, fine bits
    endcase
    return v;
  endfunction

  // random element: mostly well-conditioned small shapes, some wide and extreme,
  // some with a repeated vertex so the determinant vanishes
  function automatic logic [IN_TDATA_W-1:0] rand_elem();
    logic [IN_TDATA_W-1:0] d;
    int kind, src, dst, w;
    w = $urandom_range(99);
    kind = (w < 40) ? 0 : (w < 65) ? 3 : (w < 85) ? 1 : 2;
    for (int k = 0; k < 12; k++) d[k*32 +: 32] = pick_coord(kind);
    if ($urandom_range(9) == 0) begin
      src = $urandom_range(3);
      dst = $urandom_range(3);
      d[dst*96 +: 96] = d[src*96 +: 96];
    end
    return d;
  endfunction

  // directed elements: zero, unit simplex, mirrored unit simplex, extremes, one-lsb simplex
  task automatic send_directed();
    logic [IN_TDATA_W-1:0] d;
    send_elem('0);                                  // all vertices coincide
    d = '0;
    d[1*96 + 0*32 +: 32] = ONE_Q16;
    d[2*96 + 1*32 +: 32] = ONE_Q16;
    d[3*96 + 2*32 +: 32] = ONE_Q16;
    send_elem(d);                                   // unit simplex
    d[1*96 + 0*32 +: 32] = -ONE_Q16;
    send_elem(d);                                   // negative orientation
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d[k*32 +: 32]             = 32'h8000_0000;
      d[(3 + k)*32 +: 32]       = 32'h7FFF_FFFF;
    end
    d[2*96 + 1*32 +: 32] = 32'h7FFF_FFFF;
    d[3*96 + 2*32 +: 32] = 32'h7FFF_FFFF;
    send_elem(d);                                   // widest span, saturating
    d = {IN_TDATA_W{1'b1}};
    send_elem(d);                                   // every bit set
    d = '0;
    d[1*96 +: 32] = 32'h0000_0001;
    d[2*96 + 32 +: 32] = 32'h0000_0001;
    d[3*96 + 64 +: 32] = 32'h0000_0001;
    send_elem(d);                                   // one-lsb simplex
  endtask

  initial begin
    dim_t dim_seq [5];
    int   n_items;
    dim_seq = '{DIM_TET, DIM_SEG, DIM_TRI, DIM_NONE, DIM_TET};
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= DIM_TET;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    out_tready  <= 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 63;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // regime 0: sender idles 31%, receiver 63%; 1: swapped; 2: no idling
    for (int reg_i = 0; reg_i < 3; reg_i++) begin
      tx_idle_pct = (reg_i == 0) ? 31 : (reg_i == 1) ? 63 : 0;
      rx_idle_pct = (reg_i == 0) ? 63 : (reg_i == 1) ? 31 : 0;
      foreach (dim_seq[p]) begin
        drain_pipe();
        write_dim(dim_seq[p]);
        if (reg_i == 0 && p < 4) send_directed();
        n_items = (dim_seq[p] == DIM_NONE) ? 4 : 42;
        for (int k = 0; k < n_items; k++) send_elem(rand_elem());
      end
    end
    drain_pipe();
    if (fail_count == 0 && rows_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
